>>> src/bmat_pkg.sv
// Shared constants, types and command/status bundles for the adaptive threshold unit.
`default_nettype none
package bmat_pkg;
    localparam int MAX_WIDTH  = 640;
    localparam int MAX_HEIGHT = 480;
    localparam int MAX_RADIUS = 63;

    localparam int PIX_W   = 8;
    localparam int COL_W   = 10;
    localparam int ROW_W   = 9;
    localparam int RAD_W   = 6;
    localparam int OFF_W   = 9;
    localparam int CFG_W   = 10;
    localparam int IDX_W   = 8;
    localparam int RS_W    = 18;
    localparam int II_W    = 27;
    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int SPAN_W  = $clog2(2 * MAX_RADIUS + 2);
    localparam int AREA_W  = 2 * SPAN_W;
    localparam int QUO_W   = PIX_W;
    localparam int QBIT_W  = $clog2(QUO_W);

    localparam logic [IDX_W-1:0] REG_WIDTH  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_HEIGHT = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_RADIUS = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_OFFSET = IDX_W'(3);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    localparam logic [PIX_W-1:0] PIX_ON  = PIX_W'(255);
    localparam logic [PIX_W-1:0] PIX_OFF = PIX_W'(0);

    typedef struct packed {
        logic              accept;
        logic              ld_rd;
        logic              ld_wr;
        logic              em_calc;
        logic              rd_issue;
        logic [1:0]        rd_corner;
        logic              div_step;
        logic [QBIT_W-1:0] div_bit;
        logic              em_out;
    } t_cmd;

    typedef struct packed {
        logic frame_loaded;
        logic out_free;
    } t_sts;
endpackage
`default_nettype wire

>>> src/bmat_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module bmat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire                     i_re,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

>>> src/bmat_ctrl.sv
// Controller state machine sequencing loads, corner reads and the mean divider.
`default_nettype none
module bmat_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_s_tvalid,
    input  wire             i_s_tuser,
    output logic            o_s_tready,
    input  bmat_pkg::t_sts  i_sts,
    output bmat_pkg::t_cmd  o_cmd
);
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_LD_RD   = 3'd1;
    localparam logic [2:0] S_LD_WR   = 3'd2;
    localparam logic [2:0] S_EM_CALC = 3'd3;
    localparam logic [2:0] S_EM_RD   = 3'd4;
    localparam logic [2:0] S_EM_SUM  = 3'd5;
    localparam logic [2:0] S_EM_DIV  = 3'd6;
    localparam logic [2:0] S_EM_OUT  = 3'd7;

    logic [2:0]                  r_state, n_state;
    logic [1:0]                  r_corner, n_corner;
    logic [bmat_pkg::QBIT_W-1:0] r_bit, n_bit;
    logic                        w_acc;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_acc      = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state  = r_state;
        n_corner = r_corner;
        n_bit    = r_bit;
        o_cmd    = '0;
        o_cmd.rd_corner = r_corner;
        o_cmd.div_bit   = r_bit;
        case (r_state)
            S_IDLE: begin
                o_cmd.accept = w_acc;
                if (w_acc) begin
                    if (i_s_tuser == bmat_pkg::OP_LOAD && !i_sts.frame_loaded) begin
                        n_state = S_LD_RD;
                    end else if (i_s_tuser == bmat_pkg::OP_EMIT && i_sts.frame_loaded) begin
                        n_state = S_EM_CALC;
                    end
                end
            end
            S_LD_RD: begin
                o_cmd.ld_rd = 1'b1;
                n_state = S_LD_WR;
            end
            S_LD_WR: begin
                o_cmd.ld_wr = 1'b1;
                n_state = S_IDLE;
            end
            S_EM_CALC: begin
                o_cmd.em_calc = 1'b1;
                n_corner = 2'd0;
                n_state = S_EM_RD;
            end
            S_EM_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_corner = r_corner + 2'd1;
                if (r_corner == 2'd3) begin
                    n_state = S_EM_SUM;
                end
            end
            S_EM_SUM: begin
                n_bit = bmat_pkg::QBIT_W'(bmat_pkg::QUO_W - 1);
                n_state = S_EM_DIV;
            end
            S_EM_DIV: begin
                o_cmd.div_step = 1'b1;
                n_bit = r_bit - 1'b1;
                if (r_bit == '0) begin
                    n_state = S_EM_OUT;
                end
            end
            S_EM_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.em_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_corner <= '0;
            r_bit    <= '0;
        end else begin
            r_state  <= n_state;
            r_corner <= n_corner;
            r_bit    <= n_bit;
        end
    end
endmodule
`default_nettype wire

>>> src/bmat_dp.sv
// Datapath: configuration, positions, pixel and integral stores, window sum, divider, output.
`default_nettype none
module bmat_dp (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_cfg_valid,
    input  wire [bmat_pkg::IDX_W-1:0]            i_cfg_index,
    input  wire [bmat_pkg::CFG_W-1:0]            i_cfg_data,
    input  wire [bmat_pkg::PIX_W-1:0]            i_s_tdata,
    input  wire                                  i_m_tready,
    output logic                                 o_m_tvalid,
    output logic [bmat_pkg::PIX_W-1:0]           o_m_tdata,
    output logic                                 o_m_tlast,
    input  bmat_pkg::t_cmd                       i_cmd,
    output bmat_pkg::t_sts                       o_sts
);
    localparam int AW = bmat_pkg::ADDR_W;
    localparam int IW = bmat_pkg::II_W;

    logic [bmat_pkg::COL_W-1:0]         r_cfg_w, w_w;
    logic [bmat_pkg::ROW_W-1:0]         r_cfg_h, w_h;
    logic [bmat_pkg::RAD_W-1:0]         r_cfg_rad;
    logic signed [bmat_pkg::OFF_W-1:0]  r_cfg_off;
    logic [bmat_pkg::COL_W-1:0]         r_ld_col, r_em_col;
    logic [bmat_pkg::ROW_W-1:0]         r_ld_row, r_em_row;
    logic [bmat_pkg::RS_W-1:0]          r_row_sum, w_row_sum;
    logic                               r_loaded;
    logic [bmat_pkg::PIX_W-1:0]         r_pix;
    logic [bmat_pkg::COL_W-1:0]         r_x0, r_x1;
    logic [bmat_pkg::ROW_W-1:0]         r_y0, r_y1;
    logic [bmat_pkg::AREA_W-1:0]        r_area;
    logic [IW-1:0]                      r_sum;
    logic [bmat_pkg::QUO_W-1:0]         r_q;
    logic                               r_acc_en, r_acc_zero, r_acc_neg;
    logic                               r_out_valid, r_out_last;
    logic [bmat_pkg::PIX_W-1:0]         r_out_data;

    logic [bmat_pkg::COL_W:0]           w_x1_raw;
    logic [bmat_pkg::ROW_W:0]           w_y1_raw;
    logic [bmat_pkg::COL_W-1:0]         w_x0, w_x1, w_cx;
    logic [bmat_pkg::ROW_W-1:0]         w_y0, w_y1, w_cy;
    logic [bmat_pkg::COL_W-1:0]         w_dx;
    logic [bmat_pkg::ROW_W-1:0]         w_dy;
    logic [AW-1:0]                      w_c_addr, w_ld_addr, w_ld_rd_addr, w_em_addr;
    logic [AW-1:0]                      w_ii_raddr, w_px_raddr;
    logic [IW-1:0]                      w_ii_rdata, w_ii_wdata, w_term, w_shift;
    logic [bmat_pkg::PIX_W-1:0]         w_px_rdata, w_thr;
    logic                               w_ld_col_end, w_ld_row_end;
    logic                               w_em_col_end, w_em_row_end, w_restart;

    always_comb begin
        w_w = r_cfg_w;
        if (r_cfg_w == '0) begin
            w_w = bmat_pkg::COL_W'(1);
        end else if (r_cfg_w > bmat_pkg::COL_W'(bmat_pkg::MAX_WIDTH)) begin
            w_w = bmat_pkg::COL_W'(bmat_pkg::MAX_WIDTH);
        end
        w_h = r_cfg_h;
        if (r_cfg_h == '0) begin
            w_h = bmat_pkg::ROW_W'(1);
        end else if (r_cfg_h > bmat_pkg::ROW_W'(bmat_pkg::MAX_HEIGHT)) begin
            w_h = bmat_pkg::ROW_W'(bmat_pkg::MAX_HEIGHT);
        end
    end

    assign w_x0 = (r_em_col < bmat_pkg::COL_W'(r_cfg_rad)) ? '0
                : r_em_col - bmat_pkg::COL_W'(r_cfg_rad);
    assign w_y0 = (r_em_row < bmat_pkg::ROW_W'(r_cfg_rad)) ? '0
                : r_em_row - bmat_pkg::ROW_W'(r_cfg_rad);
    assign w_x1_raw = {1'b0, r_em_col} + (bmat_pkg::COL_W+1)'(r_cfg_rad) + 1'b1;
    assign w_y1_raw = {1'b0, r_em_row} + (bmat_pkg::ROW_W+1)'(r_cfg_rad) + 1'b1;
    assign w_x1 = (w_x1_raw > {1'b0, w_w}) ? w_w : w_x1_raw[bmat_pkg::COL_W-1:0];
    assign w_y1 = (w_y1_raw > {1'b0, w_h}) ? w_h : w_y1_raw[bmat_pkg::ROW_W-1:0];
    assign w_dx = w_x1 - w_x0;
    assign w_dy = w_y1 - w_y0;

    assign w_cy = i_cmd.rd_corner[1] ? r_y1 : r_y0;
    assign w_cx = i_cmd.rd_corner[0] ? r_x1 : r_x0;
    assign w_c_addr = AW'(w_cy - 1'b1) * AW'(bmat_pkg::MAX_WIDTH) + AW'(w_cx - 1'b1);
    assign w_ld_addr = AW'(r_ld_row) * AW'(bmat_pkg::MAX_WIDTH) + AW'(r_ld_col);
    assign w_ld_rd_addr = AW'(r_ld_row - 1'b1) * AW'(bmat_pkg::MAX_WIDTH) + AW'(r_ld_col);
    assign w_em_addr = AW'(r_em_row) * AW'(bmat_pkg::MAX_WIDTH) + AW'(r_em_col);

    assign w_ii_raddr = i_cmd.ld_rd ? w_ld_rd_addr : w_c_addr;
    assign w_px_raddr = w_em_addr;
    assign w_row_sum  = r_row_sum + bmat_pkg::RS_W'(r_pix);
    assign w_ii_wdata = ((r_ld_row == '0) ? '0 : w_ii_rdata) + IW'(w_row_sum);

    bmat_ram #(.WIDTH(IW), .DEPTH(bmat_pkg::DEPTH)) u_ii_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ld_wr),
        .i_waddr (w_ld_addr),
        .i_wdata (w_ii_wdata),
        .i_re    (i_cmd.ld_rd | i_cmd.rd_issue),
        .i_raddr (w_ii_raddr),
        .o_rdata (w_ii_rdata)
    );

    bmat_ram #(.WIDTH(bmat_pkg::PIX_W), .DEPTH(bmat_pkg::DEPTH)) u_px_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ld_wr),
        .i_waddr (w_ld_addr),
        .i_wdata (r_pix),
        .i_re    (i_cmd.em_calc),
        .i_raddr (w_px_raddr),
        .o_rdata (w_px_rdata)
    );

    assign w_term  = r_acc_zero ? '0 : w_ii_rdata;
    assign w_shift = IW'(r_area) << i_cmd.div_bit;
    assign w_thr   = r_q - r_cfg_off[bmat_pkg::PIX_W-1:0];

    assign w_ld_col_end = ({1'b0, r_ld_col} + 1'b1) >= {1'b0, w_w};
    assign w_ld_row_end = ({1'b0, r_ld_row} + 1'b1) >= {1'b0, w_h};
    assign w_em_col_end = ({1'b0, r_em_col} + 1'b1) >= {1'b0, w_w};
    assign w_em_row_end = ({1'b0, r_em_row} + 1'b1) >= {1'b0, w_h};
    assign w_restart = (i_cfg_valid && (i_cfg_index == bmat_pkg::REG_WIDTH
                                     || i_cfg_index == bmat_pkg::REG_HEIGHT))
                    || (i_cmd.em_out && w_em_col_end && w_em_row_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w     <= bmat_pkg::COL_W'(bmat_pkg::MAX_WIDTH);
            r_cfg_h     <= bmat_pkg::ROW_W'(bmat_pkg::MAX_HEIGHT);
            r_cfg_rad   <= '0;
            r_cfg_off   <= '0;
            r_ld_col    <= '0;
            r_ld_row    <= '0;
            r_em_col    <= '0;
            r_em_row    <= '0;
            r_row_sum   <= '0;
            r_loaded    <= 1'b0;
            r_acc_en    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    bmat_pkg::REG_WIDTH:  r_cfg_w   <= i_cfg_data[bmat_pkg::COL_W-1:0];
                    bmat_pkg::REG_HEIGHT: r_cfg_h   <= i_cfg_data[bmat_pkg::ROW_W-1:0];
                    bmat_pkg::REG_RADIUS: r_cfg_rad <= i_cfg_data[bmat_pkg::RAD_W-1:0];
                    bmat_pkg::REG_OFFSET: r_cfg_off <= i_cfg_data[bmat_pkg::OFF_W-1:0];
                    default: ;
                endcase
            end
            r_acc_en <= i_cmd.rd_issue;
            if (i_cmd.ld_wr) begin
                if (w_ld_col_end) begin
                    r_ld_col  <= '0;
                    r_row_sum <= '0;
                    if (w_ld_row_end) begin
                        r_ld_row <= '0;
                        r_loaded <= 1'b1;
                    end else begin
                        r_ld_row <= r_ld_row + 1'b1;
                    end
                end else begin
                    r_ld_col  <= r_ld_col + 1'b1;
                    r_row_sum <= w_row_sum;
                end
            end
            if (i_cmd.em_out) begin
                if (w_em_col_end) begin
                    r_em_col <= '0;
                    r_em_row <= r_em_row + 1'b1;
                end else begin
                    r_em_col <= r_em_col + 1'b1;
                end
            end
            if (w_restart) begin
                r_ld_col  <= '0;
                r_ld_row  <= '0;
                r_em_col  <= '0;
                r_em_row  <= '0;
                r_row_sum <= '0;
                r_loaded  <= 1'b0;
            end
            if (i_cmd.em_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pix <= i_s_tdata;
        end
        if (i_cmd.em_calc) begin
            r_x0   <= w_x0;
            r_x1   <= w_x1;
            r_y0   <= w_y0;
            r_y1   <= w_y1;
            r_area <= w_dx[bmat_pkg::SPAN_W-1:0] * w_dy[bmat_pkg::SPAN_W-1:0];
            r_sum  <= '0;
            r_q    <= '0;
        end
        r_acc_zero <= (w_cy == '0) || (w_cx == '0);
        r_acc_neg  <= i_cmd.rd_corner[0] ^ i_cmd.rd_corner[1];
        if (r_acc_en) begin
            r_sum <= r_acc_neg ? r_sum - w_term : r_sum + w_term;
        end
        if (i_cmd.div_step && r_sum >= w_shift) begin
            r_sum <= r_sum - w_shift;
            r_q[i_cmd.div_bit] <= 1'b1;
        end
        if (i_cmd.em_out) begin
            r_out_data <= (w_px_rdata > w_thr) ? bmat_pkg::PIX_ON : bmat_pkg::PIX_OFF;
            r_out_last <= w_em_col_end && w_em_row_end;
        end
    end

    assign o_sts.frame_loaded = r_loaded;
    assign o_sts.out_free     = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
endmodule
`default_nettype wire

>>> src/box_mean_adaptive_threshold_unit.sv
// Top level of the box mean adaptive threshold unit.
// Input stream: tuser carries the opcode (load or emit), tdata the pixel value.
// Load transactions fill the frame in raster order; each goes through accept,
// integral read, then integral and pixel write through their RAM write ports.
// Once the frame is complete, each emit transaction yields one output
// transaction: tdata is 255 or 0, tlast marks the last pixel of the frame.
// An emit runs from accept to output valid through window setup, four corner
// reads on the single integral RAM read port, a sum step and an 8-step
// restoring divider, then the output register; no input is taken meanwhile.
// Emits before the frame is complete and loads after it are absorbed with no
// output. Configuration writes (index, data) are always ready and are to be
// issued only while idle (not enforced); a width or height write restarts
// the frame. Reset clears positions and the output valid and loads default
// geometry; stores need no clearing pass. When the receiver stalls, the
// result holds in the output register and the next input is still accepted;
// a following emit waits at its last step until the register is free.
`default_nettype none
module box_mean_adaptive_threshold_unit (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire [bmat_pkg::IDX_W-1:0]       i_cfg_index,
    input  wire [bmat_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire                             i_s_tvalid,
    output logic                            o_s_tready,
    input  wire [bmat_pkg::PIX_W-1:0]       i_s_tdata,   // [7:0] pixel_value
    input  wire                             i_s_tuser,   // [0] opcode
    output logic                            o_m_tvalid,
    input  wire                             i_m_tready,
    output logic [bmat_pkg::PIX_W-1:0]      o_m_tdata,   // [7:0] binary_pixel
    output logic                            o_m_tlast
);
    bmat_pkg::t_cmd w_cmd;
    bmat_pkg::t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    bmat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tuser  (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    bmat_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts)
    );
endmodule
`default_nettype wire

>>> src/bmat_checker.sv
// Port-level checker for the adaptive threshold unit and its bind.
`default_nettype none
module bmat_checker (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        o_s_tready,
    input wire                        o_m_tvalid,
    input wire                        i_m_tready,
    input wire [bmat_pkg::PIX_W-1:0]  o_m_tdata,
    input wire                        o_m_tlast
);
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled output changed");

    a_binary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata == bmat_pkg::PIX_ON || o_m_tdata == bmat_pkg::PIX_OFF))
        else $error("output pixel not binary");

    a_busy_before_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(!o_s_tready))
        else $error("result appeared while input side idle");
endmodule

bind box_mean_adaptive_threshold_unit bmat_checker u_bmat_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
`default_nettype wire

>>> tb/box_mean_adaptive_threshold_unit_test.sv
// Self-checking stream testbench for the box mean adaptive threshold unit.
`default_nettype none
module box_mean_adaptive_threshold_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int II_STRIDE = bmat_pkg::MAX_WIDTH + 1;

    typedef struct packed {
        logic                       op;
        logic [bmat_pkg::PIX_W-1:0] pix;
    } t_item;

    typedef struct packed {
        logic [bmat_pkg::PIX_W-1:0] bin;
        logic                       last;
    } t_result;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [bmat_pkg::IDX_W-1:0] i_cfg_index;
    logic [bmat_pkg::CFG_W-1:0] i_cfg_data;
    logic                       i_s_tvalid;
    logic                       o_s_tready;
    logic [bmat_pkg::PIX_W-1:0] i_s_tdata;
    logic                       i_s_tuser;
    logic                       o_m_tvalid;
    logic                       i_m_tready;
    logic [bmat_pkg::PIX_W-1:0] o_m_tdata;
    logic                       o_m_tlast;

    box_mean_adaptive_threshold_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tlast(o_m_tlast)
    );

    t_item   pixel_items[$];
    t_result thresh_q[$];
    int      errors = 0;
    int      items_sent = 0;
    int      pixels_out = 0;
    int      frames_out = 0;
    int      cfg_writes = 0;

    // predictor state
    logic [bmat_pkg::PIX_W-1:0] pix_mem [bmat_pkg::DEPTH];
    logic [bmat_pkg::II_W-1:0]  ii_mem  [II_STRIDE * (bmat_pkg::MAX_HEIGHT + 1)];
    logic [bmat_pkg::COL_W-1:0] cfg_w;
    logic [bmat_pkg::ROW_W-1:0] cfg_h;
    logic [bmat_pkg::RAD_W-1:0] cfg_rad;
    int                         cfg_off;
    logic [bmat_pkg::RS_W-1:0]  row_sum;
    int                         ld_col, ld_row, em_col, em_row;
    bit                         loaded;

    function automatic int eff_w_of(int v);
        return (v == 0) ? 1 : (v > bmat_pkg::MAX_WIDTH ? bmat_pkg::MAX_WIDTH : v);
    endfunction

    function automatic int eff_h_of(int v);
        return (v == 0) ? 1 : (v > bmat_pkg::MAX_HEIGHT ? bmat_pkg::MAX_HEIGHT : v);
    endfunction

    function automatic void restart_frame();
        row_sum = '0;
        ld_col = 0; ld_row = 0; em_col = 0; em_row = 0;
        loaded = 0;
    endfunction

    function automatic void apply_cfg(logic [bmat_pkg::IDX_W-1:0] idx,
                                      logic [bmat_pkg::CFG_W-1:0] val);
        case (idx)
            bmat_pkg::REG_WIDTH: begin
                cfg_w = val[bmat_pkg::COL_W-1:0];
                restart_frame();
            end
            bmat_pkg::REG_HEIGHT: begin
                cfg_h = val[bmat_pkg::ROW_W-1:0];
                restart_frame();
            end
            bmat_pkg::REG_RADIUS: cfg_rad = val[bmat_pkg::RAD_W-1:0];
            bmat_pkg::REG_OFFSET: cfg_off = int'(signed'(val[bmat_pkg::OFF_W-1:0]));
            default: ;
        endcase
    endfunction

    function automatic void threshold_step(t_item it);
        int w, h, rad, x0, x1, y0, y1, area, sum, mean, thr;
        t_result r;
        w = eff_w_of(cfg_w);
        h = eff_h_of(cfg_h);
        if (it.op == bmat_pkg::OP_LOAD) begin
            if (loaded) return;
            pix_mem[ld_row * bmat_pkg::MAX_WIDTH + ld_col] = it.pix;
            row_sum = row_sum + bmat_pkg::RS_W'(it.pix);
            ii_mem[(ld_row + 1) * II_STRIDE + ld_col + 1] =
                ii_mem[ld_row * II_STRIDE + ld_col + 1] + bmat_pkg::II_W'(row_sum);
            if (ld_col + 1 >= w) begin
                ld_col = 0;
                row_sum = '0;
                if (ld_row + 1 >= h) begin
                    ld_row = 0;
                    loaded = 1;
                end else ld_row++;
            end else ld_col++;
            return;
        end
        if (!loaded) return;
        rad = (cfg_rad > bmat_pkg::MAX_RADIUS) ? bmat_pkg::MAX_RADIUS : cfg_rad;
        x0 = em_col - rad; x1 = em_col + rad + 1;
        y0 = em_row - rad; y1 = em_row + rad + 1;
        if (x0 < 0) x0 = 0;
        if (y0 < 0) y0 = 0;
        if (x1 > w) x1 = w;
        if (y1 > h) y1 = h;
        area = (x1 - x0) * (y1 - y0);
        sum = ii_mem[y1 * II_STRIDE + x1] + ii_mem[y0 * II_STRIDE + x0]
            - ii_mem[y0 * II_STRIDE + x1] - ii_mem[y1 * II_STRIDE + x0];
        mean = (area != 0) ? sum / area : 0;
        thr = (mean - cfg_off) & 8'hFF;
        r.bin = (pix_mem[em_row * bmat_pkg::MAX_WIDTH + em_col] > thr)
              ? bmat_pkg::PIX_ON : bmat_pkg::PIX_OFF;
        r.last = 1'b0;
        if (em_col + 1 >= w) begin
            em_col = 0;
            if (em_row + 1 >= h) begin
                r.last = 1'b1;
                restart_frame();
            end else em_row++;
        end else em_col++;
        thresh_q.push_back(r);
    endfunction

    function automatic int pick_gap(bit burst);
        int k;
        if (burst) return 0;
        k = $urandom_range(99);
        if (k < 60) return 0;
        if (k < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // driver
    int src_gap = 0;
    bit src_burst = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= '0;
            i_s_tuser  <= bmat_pkg::OP_LOAD;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                threshold_step('{op: i_s_tuser, pix: i_s_tdata});
                items_sent++;
                if ($urandom_range(199) == 0) src_burst = !src_burst;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_s_tvalid <= 1'b0;
                end else if (pixel_items.size() > 0) begin
                    t_item it;
                    it = pixel_items.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tuser  <= it.op;
                    i_s_tdata  <= it.pix;
                    src_gap = pick_gap(src_burst);
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int  sink_gap = 0;
    bit  pressed = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (thresh_q.size() == 0) begin
                    $display("%0t: unexpected output tdata=%0d tlast=%0b",
                             $time, o_m_tdata, o_m_tlast);
                    errors++;
                end else begin
                    t_result e;
                    e = thresh_q.pop_front();
                    if (o_m_tdata !== e.bin) begin
                        $display("%0t: tdata mismatch expected %0d actual %0d",
                                 $time, e.bin, o_m_tdata);
                        errors++;
                    end
                    if (o_m_tlast !== e.last) begin
                        $display("%0t: tlast mismatch expected %0b actual %0b",
                                 $time, e.last, o_m_tlast);
                        errors++;
                    end
                end
                pixels_out++;
                if (o_m_tlast) frames_out++;
                if (pixels_out == 300 && !pressed) begin
                    pressed = 1;
                    sink_gap = 2500;
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                i_m_tready <= 1'b0;
            end else if ($urandom_range(99) < 25) begin
                sink_gap = pick_gap(0);
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #30_000_000;
        $display("box_mean_adaptive_threshold_unit_test: done, errors");
        $finish;
    end

    task automatic wait_idle();
        while (pixel_items.size() != 0 || i_s_tvalid || thresh_q.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [bmat_pkg::IDX_W-1:0] idx,
                             logic [bmat_pkg::CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_cfg(idx, val);
        cfg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic push_op(logic op, logic [bmat_pkg::PIX_W-1:0] p);
        pixel_items.push_back('{op: op, pix: p});
    endtask

    // frame of loads then emits, or only some loads when partial, with early emits and late loads as noise
    task automatic push_frame(int w, int h, int fill, int noise_pct, bit partial);
        int n, nl;
        logic [bmat_pkg::PIX_W-1:0] p;
        n = w * h;
        nl = partial ? $urandom_range(n - 1, 0) : n;
        for (int i = 0; i < nl; i++) begin
            case (fill)
                1: p = '0;
                2: p = '1;
                3: p = bmat_pkg::PIX_W'($urandom_range(140, 116));
                default: p = bmat_pkg::PIX_W'($urandom);
            endcase
            if (i < n - 1 && $urandom_range(99) < noise_pct)
                push_op(bmat_pkg::OP_EMIT, bmat_pkg::PIX_W'($urandom));
            push_op(bmat_pkg::OP_LOAD, p);
        end
        if (partial) return;
        for (int i = 0; i < n; i++) begin
            push_op(bmat_pkg::OP_EMIT, bmat_pkg::PIX_W'($urandom));
            if (i < n - 1 && $urandom_range(99) < noise_pct)
                push_op(bmat_pkg::OP_LOAD, bmat_pkg::PIX_W'($urandom));
        end
    endtask

    initial begin
        int w, h, k, ph;
        logic [bmat_pkg::CFG_W-1:0] v;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        cfg_w = bmat_pkg::COL_W'(bmat_pkg::MAX_WIDTH);
        cfg_h = bmat_pkg::ROW_W'(bmat_pkg::MAX_HEIGHT);
        cfg_rad = '0;
        cfg_off = 0;
        foreach (ii_mem[i]) ii_mem[i] = '0;
        restart_frame();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: early emit, small frame, extremes of pixel and offset, zero geometry
        push_op(bmat_pkg::OP_EMIT, 8'hFF);
        wait_idle();
        write_reg(bmat_pkg::REG_WIDTH, 10'd3);
        write_reg(bmat_pkg::REG_HEIGHT, 10'd2);
        write_reg(bmat_pkg::REG_RADIUS, 10'd1);
        write_reg(bmat_pkg::REG_OFFSET, 10'h101);
        push_op(bmat_pkg::OP_LOAD, 8'h00); push_op(bmat_pkg::OP_LOAD, 8'hFF);
        push_op(bmat_pkg::OP_EMIT, 8'h00);
        push_op(bmat_pkg::OP_LOAD, 8'h80); push_op(bmat_pkg::OP_LOAD, 8'h7F);
        push_op(bmat_pkg::OP_LOAD, 8'h01); push_op(bmat_pkg::OP_LOAD, 8'hFE);
        push_op(bmat_pkg::OP_EMIT, 8'h00); push_op(bmat_pkg::OP_LOAD, 8'h55);
        push_op(bmat_pkg::OP_EMIT, 8'hAA);
        for (int i = 0; i < 4; i++) push_op(bmat_pkg::OP_EMIT, 8'h00);
        wait_idle();
        write_reg(bmat_pkg::REG_OFFSET, 10'h0FF);
        write_reg(8'd200, 10'h3FF);
        push_frame(3, 2, 2, 0, 0);
        wait_idle();
        write_reg(bmat_pkg::REG_WIDTH, 10'd0);
        write_reg(bmat_pkg::REG_HEIGHT, 10'd0);
        push_frame(1, 1, 0, 0, 0);

        // random phases
        ph = 0;
        while (items_sent + pixel_items.size() < 1750 || ph < 8) begin
            wait_idle();
            k = $urandom_range(99);
            if (ph == 3) begin
                v = 10'h3FF;
                write_reg(bmat_pkg::REG_WIDTH, v);
                write_reg(bmat_pkg::REG_HEIGHT, 10'd1);
            end else if (ph == 5) begin
                write_reg(bmat_pkg::REG_WIDTH, 10'd1);
                write_reg(bmat_pkg::REG_HEIGHT, 10'h1FF);
            end else if (k < 70 || ph < 2) begin
                write_reg(bmat_pkg::REG_WIDTH,
                          bmat_pkg::CFG_W'($urandom_range(12, 1)));
                write_reg(bmat_pkg::REG_HEIGHT,
                          {1'($urandom), bmat_pkg::ROW_W'($urandom_range(10, 1))});
            end
            if ($urandom_range(99) < 60) begin
                k = $urandom_range(99);
                v = (k < 15) ? bmat_pkg::CFG_W'(bmat_pkg::MAX_RADIUS)
                             : bmat_pkg::CFG_W'($urandom_range(4));
                v[bmat_pkg::CFG_W-1:bmat_pkg::RAD_W] =
                    (bmat_pkg::CFG_W - bmat_pkg::RAD_W)'($urandom);
                write_reg(bmat_pkg::REG_RADIUS, v);
            end
            if ($urandom_range(99) < 60) begin
                k = $urandom_range(99);
                if (k < 15) v = bmat_pkg::CFG_W'(-255);
                else if (k < 30) v = bmat_pkg::CFG_W'(255);
                else v = bmat_pkg::CFG_W'($urandom_range(40) - 20);
                v[bmat_pkg::CFG_W-1] = 1'($urandom);
                write_reg(bmat_pkg::REG_OFFSET, v);
            end
            if ($urandom_range(99) < 5)
                write_reg(bmat_pkg::IDX_W'($urandom_range(255, 4)),
                          bmat_pkg::CFG_W'($urandom));
            w = eff_w_of(cfg_w);
            h = eff_h_of(cfg_h);
            if (loaded || ld_col != 0 || ld_row != 0) begin
                write_reg(bmat_pkg::REG_WIDTH, cfg_w);
            end
            push_frame(w, h, $urandom_range(5) > 3 ? $urandom_range(3, 1) : 0,
                       $urandom_range(10),
                       (w * h > 1 && (ph == 5 || $urandom_range(99) < 8)));
            ph++;
        end

        wait_idle();
        repeat (60) @(posedge i_clk);
        $display("covered %0d input transactions, %0d output pixels, %0d frames",
                 items_sent, pixels_out, frames_out);
        $display("register writes: %0d, long output stall applied: %0b", cfg_writes, pressed);
        if (errors == 0) begin
            $display("box_mean_adaptive_threshold_unit_test: done, clean");
        end else begin
            $display("box_mean_adaptive_threshold_unit_test: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
